// ----- hw/rtl/calendar_date_add_days_assert.svh -----
// Assertion macros shared by the calendar date adder modules.
`ifndef CALENDAR_DATE_ADD_DAYS_ASSERT_SVH
`define CALENDAR_DATE_ADD_DAYS_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CDAD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calendar_date_add_days: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CDAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calendar_date_add_days: next-cycle check failed");

`endif

// ----- hw/rtl/cdad_pkg.sv -----
// Types, constants and calendar functions for the calendar date adder.
package cdad_pkg;

   // Number of low bits of the day count that are used.
   localparam int COUNT_WIDTH = 16;
   // Width of the month-stepping arithmetic: at least wide enough for a day of month.
   localparam int STEP_WIDTH = (COUNT_WIDTH > 5) ? COUNT_WIDTH : 5;

   // Year limits, both exclusive.
   localparam logic [11:0] YEAR_LOW  = 12'd1000;
   localparam logic [11:0] YEAR_HIGH = 12'd4000;

   // Month codes.
   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // Month lengths.
   localparam logic [4:0] DAYS_LONG  = 5'd31;
   localparam logic [4:0] DAYS_SHORT = 5'd30;
   localparam logic [4:0] DAYS_LEAP  = 5'd29;
   localparam logic [4:0] DAYS_FEB   = 5'd28;

   // Fields of one request transfer.
   typedef struct packed {
      logic [4:0]  day_in;
      logic [3:0]  month_in;
      logic [11:0] year_in;
      logic [15:0] days_to_add;
   } req_type;

   // Fields of one result transfer.
   typedef struct packed {
      logic        date_valid;
      logic [4:0]  day_out;
      logic [3:0]  month_out;
      logic [12:0] year_out;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic finished;
   } status_type;

   // Length of a month; leap is set when the year is divisible by four.
   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      if (month == MONTH_FEB) begin
         len = leap ? DAYS_LEAP : DAYS_FEB;
      end else if (month inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
         len = DAYS_SHORT;
      end else begin
         len = DAYS_LONG;
      end
      return len;
   endfunction

   // Check a date against the year window, the month range and the month length.
   function automatic logic date_ok(input logic [4:0] day, input logic [3:0] month,
                                    input logic [11:0] year);
      logic ok;
      ok = (year > YEAR_LOW) && (year < YEAR_HIGH) &&
           (month >= MONTH_JAN) && (month <= MONTH_DEC) &&
           (day != 5'd0) && (day <= month_length(month, year[1:0] == 2'd0));
      return ok;
   endfunction

endpackage

// ----- hw/rtl/cdad_ctrl.sv -----
// Controller state machine that sequences one date through the datapath.
`include "calendar_date_add_days_assert.svh"

module cdad_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output cdad_pkg::cmd_type    cmd,
   input  cdad_pkg::status_type status
);
   import cdad_pkg::*;

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   // Load on an accepted request; step until the datapath reports the date finished.
   always_comb begin
      cmd.load = start && !busy_ff;
      cmd.step = (state_ff == RUN) && !status.finished;
   end

   // State and registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (start) begin
                  state_ff <= RUN;
                  busy_ff  <= 1'b1;
               end
            end
            RUN: begin
               if (status.finished) begin
                  state_ff  <= IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   // A result transfer never overlaps work in progress.
   `CDAD_ASSERT_NOW(a_strobe_idle, clock, reset, strobe_ff, !busy_ff && state_ff == IDLE)
   // An accepted request always makes the block busy.
   `CDAD_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy_ff, busy_ff)
   // Finishing while running always produces exactly one result transfer.
   `CDAD_ASSERT_NEXT(a_finish_strobe, clock, reset, state_ff == RUN && status.finished,
                     strobe_ff && !busy_ff)

endmodule

// ----- hw/rtl/cdad_dp.sv -----
// Datapath that checks a date and advances it one month boundary per step.
`include "calendar_date_add_days_assert.svh"

module cdad_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  cdad_pkg::cmd_type    cmd,
   input  cdad_pkg::req_type    req_payload,
   output cdad_pkg::status_type status,
   output cdad_pkg::rsp_type    rsp_payload
);
   import cdad_pkg::*;

   logic [4:0]             day_ff;
   logic [3:0]             month_ff;
   logic [12:0]            year_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   valid_ff;

   logic [4:0]             day_in;
   logic [3:0]             month_in;
   logic [12:0]            year_in;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   valid_in;

   logic [4:0]             month_len;
   logic [STEP_WIDTH-1:0]  left_ext;
   logic [STEP_WIDTH-1:0]  count_ext;
   logic [STEP_WIDTH-1:0]  count_rest;

   // Days still available in the current month, and the count that remains past it.
   always_comb begin
      month_len  = month_length(month_ff, year_ff[1:0] == 2'd0);
      left_ext   = STEP_WIDTH'(month_len - day_ff);
      count_ext  = STEP_WIDTH'(count_ff);
      count_rest = count_ext - left_ext - STEP_WIDTH'(1);
   end

   // Next date: load a request, or finish inside this month, or roll into the next one.
   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      if (cmd.load) begin
         day_in   = req_payload.day_in;
         month_in = req_payload.month_in;
         year_in  = 13'(req_payload.year_in);
         count_in = COUNT_WIDTH'(req_payload.days_to_add);
         valid_in = date_ok(req_payload.day_in, req_payload.month_in, req_payload.year_in);
      end else if (cmd.step) begin
         if (count_ext <= left_ext) begin
            day_in   = day_ff + count_ext[4:0];
            count_in = '0;
         end else begin
            day_in   = 5'd1;
            count_in = count_rest[COUNT_WIDTH-1:0];
            if (month_ff == MONTH_DEC) begin
               month_in = MONTH_JAN;
               year_in  = year_ff + 13'd1;
            end else begin
               month_in = month_ff + 4'd1;
            end
         end
      end
   end

   // Date and count registers; payload only, so no reset.
   always_ff @(posedge clock) begin
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      count_ff <= count_in;
      valid_ff <= valid_in;
   end

   assign status.finished = !valid_ff || (count_ff == '0);

   assign rsp_payload.date_valid = valid_ff;
   assign rsp_payload.day_out    = day_ff;
   assign rsp_payload.month_out  = month_ff;
   assign rsp_payload.year_out   = year_ff;

   // Each step strictly shrinks the remaining count.
   `CDAD_ASSERT_NEXT(a_step_shrinks, clock, reset, cmd.step && !cmd.load,
                     count_ff < $past(count_ff))
   // Stepping keeps the date inside the calendar.
   `CDAD_ASSERT_NEXT(a_step_in_range, clock, reset, cmd.step && !cmd.load,
                     day_ff != 5'd0 && month_ff >= MONTH_JAN && month_ff <= MONTH_DEC)
   // Only a valid date is ever stepped.
   `CDAD_ASSERT_NOW(a_step_valid, clock, reset, cmd.step, valid_ff)

endmodule

// ----- hw/rtl/calendar_date_add_days.sv -----
// Top level of the calendar date adder: Julian leap rule, one result per request.
//
// A request transfer is taken at a rising edge with start high and busy low, and that edge
// loads the date and checks it. After that the datapath takes one step per cycle. Each step
// either crosses one month end or finishes the count inside the current month. When the
// count is used up, the controller sees the finished status and registers rsp_strobe, so the
// result follows in the cycle after that. The number of steps S is M, the number of month
// ends passed, plus one unless the count runs out exactly on the first day of a month. M is
// at most days_to_add / 28 + 1 (2341 for the largest count). An invalid date or a zero count
// takes no step. The result is on rsp_payload for exactly one cycle, marked by rsp_strobe.
// The receiver cannot stall it and must take it then. A new request may be presented in the
// same cycle as the strobe.
module calendar_date_add_days (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cdad_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output cdad_pkg::rsp_type rsp_payload
);
   import cdad_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing.
   cdad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // Date arithmetic.
   cdad_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- dv/calendar_date_add_days_checker.sv -----
`timescale 1ns / 100ps
// Checker for the calendar date adder: predicts each result and compares the result transfers.
module calendar_date_add_days_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  cdad_pkg::req_type req_payload,
   input  logic              rsp_strobe,
   input  cdad_pkg::rsp_type rsp_payload,
   output int unsigned       mismatch_count,
   output int unsigned       dates_in_flight
);
   import cdad_pkg::*;

   // Predicted results, oldest request first.
   rsp_type expected_dates[$];
   int unsigned errors_seen = 0;

   // Month length under the Julian rule: every fourth year is a leap year.
   function automatic int unsigned days_in_month(input int unsigned month,
                                                 input int unsigned year);
      int unsigned len;
      if (month == 32'(MONTH_FEB)) begin
         len = (year % 4 == 0) ? 32'(DAYS_LEAP) : 32'(DAYS_FEB);
      end else if (month == 32'(MONTH_APR) || month == 32'(MONTH_JUN) ||
                   month == 32'(MONTH_SEP) || month == 32'(MONTH_NOV)) begin
         len = 32'(DAYS_SHORT);
      end else begin
         len = 32'(DAYS_LONG);
      end
      return len;
   endfunction

   // Check the date, then walk it forward one month boundary at a time.
   function automatic rsp_type advance_date(input req_type item);
      int unsigned day;
      int unsigned month;
      int unsigned year;
      int unsigned remaining;
      int unsigned room;
      rsp_type     result;
      day       = 32'(item.day_in);
      month     = 32'(item.month_in);
      year      = 32'(item.year_in);
      remaining = 32'(item.days_to_add) % (32'd1 << COUNT_WIDTH);
      result.date_valid = (year > 32'(YEAR_LOW)) && (year < 32'(YEAR_HIGH)) &&
                          (month >= 32'(MONTH_JAN)) && (month <= 32'(MONTH_DEC)) &&
                          (day >= 1) && (day <= days_in_month(month, year));
      // An invalid date is echoed as it came in and the count is ignored.
      if (result.date_valid) begin
         while (remaining > 0) begin
            room = days_in_month(month, year) - day;
            if (remaining <= room) begin
               day       += remaining;
               remaining = 0;
            end else begin
               remaining -= room + 1;
               day       = 1;
               if (month == 32'(MONTH_DEC)) begin
                  month = 32'(MONTH_JAN);
                  year++;
               end else begin
                  month++;
               end
            end
         end
      end
      result.day_out   = 5'(day);
      result.month_out = 4'(month);
      result.year_out  = 13'(year);
      return result;
   endfunction

   // Results are matched before new requests are queued, since a result can never
   // belong to a request taken at the same edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_dates.delete();
         dates_in_flight <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_dates.size() == 0) begin
               $error("result transfer with no date pending");
               errors_seen++;
            end else begin
               want = expected_dates.pop_front();
               if (rsp_payload.date_valid !== want.date_valid) begin
                  $error("date_valid: expected %0d, got %0d",
                         want.date_valid, rsp_payload.date_valid);
                  errors_seen++;
               end
               if (rsp_payload.day_out !== want.day_out) begin
                  $error("day_out: expected %0d, got %0d", want.day_out, rsp_payload.day_out);
                  errors_seen++;
               end
               if (rsp_payload.month_out !== want.month_out) begin
                  $error("month_out: expected %0d, got %0d",
                         want.month_out, rsp_payload.month_out);
                  errors_seen++;
               end
               if (rsp_payload.year_out !== want.year_out) begin
                  $error("year_out: expected %0d, got %0d", want.year_out, rsp_payload.year_out);
                  errors_seen++;
               end
            end
         end
         if (start && !busy) begin
            expected_dates.push_back(advance_date(req_payload));
         end
         dates_in_flight <= expected_dates.size();
      end
      mismatch_count <= errors_seen;
   end

endmodule

// ----- dv/calendar_date_add_days_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the calendar date adder: clock, reset, date stimulus and verdict.
module calendar_date_add_days_tb;
   import cdad_pkg::*;

   // Longest correct stretch without a transfer is no longer than one full-count item or the
   // longest sender gap, whichever is longer; this limit leaves ample margin.
   localparam int unsigned IDLE_LIMIT   = 20000;
   localparam int unsigned RANDOM_ITEMS = 78;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        rsp_strobe;
   req_type     req_payload;
   rsp_type     rsp_payload;
   int unsigned mismatch_count;
   int unsigned dates_in_flight;
   int unsigned idle_cycles = 0;

   calendar_date_add_days u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   calendar_date_add_days_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_payload     (req_payload),
      .rsp_strobe      (rsp_strobe),
      .rsp_payload     (rsp_payload),
      .mismatch_count  (mismatch_count),
      .dates_in_flight (dates_in_flight)
   );

   // 10 ns clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_date(input logic [4:0] day, input logic [3:0] month,
                                         input logic [11:0] year, input logic [15:0] count);
      req_type item;
      item.day_in      = day;
      item.month_in    = month;
      item.year_in     = year;
      item.days_to_add = count;
      return item;
   endfunction

   // Mostly plausible dates with month ends and leap years favored; the rest is noise.
   function automatic req_type random_date();
      req_type     item;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         item.month_in = 4'($urandom_range(1, 12));
         if ($urandom_range(0, 3) == 0) begin
            item.year_in = 12'(4 * $urandom_range(251, 999));
         end else begin
            item.year_in = 12'($urandom_range(1001, 3999));
         end
         if ($urandom_range(0, 3) == 0) begin
            item.day_in = 5'($urandom_range(28, 31));
         end else begin
            item.day_in = 5'($urandom_range(1, 27));
         end
      end else begin
         item.day_in   = 5'($urandom);
         item.month_in = 4'($urandom);
         item.year_in  = 12'($urandom);
      end
      // Most counts are short; a few use the full range and keep the block busy.
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         item.days_to_add = 16'($urandom_range(0, 40));
      end else if (roll < 85) begin
         item.days_to_add = 16'($urandom_range(0, 1500));
      end else begin
         item.days_to_add = 16'($urandom);
      end
      return item;
   endfunction

   // Present one date until it is taken, then idle for a random gap, often none.
   task automatic send_date(input req_type item);
      int unsigned roll;
      int unsigned gap;
      req_payload <= item;
      start       <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         gap = 0;
      end else if (roll < 90) begin
         gap = $urandom_range(1, 4);
      end else begin
         gap = $urandom_range(10, 150);
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Year window edges, zero count and the largest count.
      send_date(make_date(5'd1, MONTH_JAN, 12'd1001, 16'd0));
      send_date(make_date(5'd31, MONTH_DEC, 12'd3999, 16'd65535));
      send_date(make_date(5'd1, MONTH_JAN, 12'd1000, 16'd7));
      send_date(make_date(5'd1, MONTH_JAN, 12'd4000, 16'd7));
      send_date(make_date(5'd0, 4'd0, 12'd0, 16'd0));
      send_date(make_date(5'd31, 4'd15, 12'd4095, 16'd65535));
      // Month and day out of range.
      send_date(make_date(5'd15, 4'd0, 12'd2010, 16'd10));
      send_date(make_date(5'd15, 4'd13, 12'd2010, 16'd10));
      send_date(make_date(5'd0, 4'd3, 12'd2010, 16'd2));
      send_date(make_date(5'd31, MONTH_APR, 12'd2010, 16'd3));
      send_date(make_date(5'd30, MONTH_APR, 12'd2010, 16'd1));
      // February under the Julian rule, with no century exception.
      send_date(make_date(5'd28, MONTH_FEB, 12'd2024, 16'd1));
      send_date(make_date(5'd28, MONTH_FEB, 12'd2023, 16'd1));
      send_date(make_date(5'd29, MONTH_FEB, 12'd1900, 16'd0));
      send_date(make_date(5'd29, MONTH_FEB, 12'd2001, 16'd5));
      send_date(make_date(5'd30, MONTH_FEB, 12'd2000, 16'd5));
      send_date(make_date(5'd31, MONTH_JAN, 12'd2012, 16'd29));
      // Rollover across month ends and into the next year.
      send_date(make_date(5'd31, MONTH_DEC, 12'd2023, 16'd1));
      send_date(make_date(5'd30, MONTH_NOV, 12'd2020, 16'd32));
      send_date(make_date(5'd31, 4'd7, 12'd3000, 16'd31));
      send_date(make_date(5'd1, 4'd3, 12'd2011, 16'd365));
      send_date(make_date(5'd1, MONTH_JAN, 12'd2000, 16'd60000));

      repeat (RANDOM_ITEMS) send_date(random_date());
      start <= 1'b0;

      // The pending count is registered, so the last request must reach it before it is polled.
      @(posedge clock);
      while (dates_in_flight != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cdad_pkg.sv
hw/rtl/cdad_ctrl.sv
hw/rtl/cdad_dp.sv
hw/rtl/calendar_date_add_days.sv
dv/calendar_date_add_days_checker.sv
dv/calendar_date_add_days_tb.sv
